// ===== rtl/core/li_ion_charge_controller_assert.svh =====
// Assertion macros shared by the charge controller RTL.
`ifndef LI_ION_CHARGE_CONTROLLER_ASSERT_SVH
`define LI_ION_CHARGE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lic_pkg.sv =====
`default_nettype none

package lic_pkg;

	localparam int VOLT_W   = 12;
	localparam int CUR_W    = 12;
	localparam int DUTY_W   = 10;
	localparam int PHASE_W  = 3;
	localparam int TIMER_W  = 13;
	localparam int FULL_W   = 10;
	localparam int RECH_W   = 5;
	localparam int STEPS_W  = 8;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 3;

	// current thresholds for the extra CV target drops at CV entry
	localparam logic [CUR_W-1:0] STEP_CURRENT_A = 12'd790;
	localparam logic [CUR_W-1:0] STEP_CURRENT_B = 12'd650;
	localparam logic [CUR_W-1:0] STEP_CURRENT_C = 12'd520;
	localparam logic [CUR_W-1:0] STEP_CURRENT_D = 12'd430;

	localparam logic [DUTY_W-1:0]  DUTY_MAX       = 10'd1020;
	localparam logic [DUTY_W-1:0]  DUTY_PRE       = 10'h042;
	localparam logic [DUTY_W-1:0]  DUTY_CC        = 10'h1cd;
	localparam logic [TIMER_W-1:0] CV_STEP_TICKS  = 13'd5400;
	localparam logic [FULL_W-1:0]  FULL_TICKS     = 10'd600;
	localparam logic [FULL_W-1:0]  FULL_DROP      = 10'd10;
	localparam logic [RECH_W-1:0]  RECHARGE_TICKS = 5'd20;
	localparam logic [CUR_W-1:0]   CUR_BAND       = 12'd4;
	localparam logic [VOLT_W-1:0]  CV_BAND        = 12'd20;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE = 3'd0,
		PH_PRE  = 3'd1,
		PH_CC   = 3'd2,
		PH_CV   = 3'd3,
		PH_RED  = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_START  = 3'd0,
		REG_PRE_LIMIT   = 3'd1,
		REG_CC_ENTRY    = 3'd2,
		REG_CV_ENTRY    = 3'd3,
		REG_RECHARGE    = 3'd4,
		REG_PRE_CURRENT = 3'd5,
		REG_CC_CURRENT  = 3'd6,
		REG_TERM_CURRENT = 3'd7
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] RST_FULL_START   = 12'd2575;
	localparam logic [CFG_W-1:0] RST_PRE_LIMIT    = 12'd1862;
	localparam logic [CFG_W-1:0] RST_CC_ENTRY     = 12'd1862;
	localparam logic [CFG_W-1:0] RST_CV_ENTRY     = 12'd2482;
	localparam logic [CFG_W-1:0] RST_RECHARGE     = 12'd2420;
	localparam logic [CFG_W-1:0] RST_PRE_CURRENT  = 12'd250;
	localparam logic [CFG_W-1:0] RST_CC_CURRENT   = 12'd950;
	localparam logic [CFG_W-1:0] RST_TERM_CURRENT = 12'd90;

	typedef struct packed {
		logic [VOLT_W-1:0] full_start;
		logic [VOLT_W-1:0] pre_limit;
		logic [VOLT_W-1:0] cc_entry;
		logic [VOLT_W-1:0] cv_entry;
		logic [VOLT_W-1:0] recharge;
		logic [CUR_W-1:0]  pre_current;
		logic [CUR_W-1:0]  cc_current;
		logic [CUR_W-1:0]  term_current;
	} lic_cfg_t;

	typedef struct packed {
		logic [VOLT_W-1:0] voltage;
		logic [CUR_W-1:0]  current;
		logic              present;
		logic              ov_cleared;
		logic              ov_fault;
		logic              temp_fault;
		logic              therm_fault;
		logic              chg_fault;
		logic              temp_marginal;
	} lic_tick_t;

	typedef struct packed {
		phase_t             phase;
		logic               complete;
		logic [DUTY_W-1:0]  duty;
		logic [VOLT_W-1:0]  cv_target;
		logic [TIMER_W-1:0] cv_timer;
		logic [FULL_W-1:0]  full_cnt;
		logic [RECH_W-1:0]  rech_cnt;
		logic [STEPS_W-1:0] step_downs;
	} lic_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lic_if.sv =====
`default_nettype none

// Tick channel: one sample set per 100 ms tick.
interface lic_item_if;
	import lic_pkg::*;

	logic              valid;
	logic              ready;
	logic [VOLT_W-1:0] battery_voltage;
	logic [CUR_W-1:0]  charge_current;
	logic              charger_present;
	logic              overvoltage_cleared;
	logic              overvoltage_fault;
	logic              temperature_fault;
	logic              thermistor_fault;
	logic              charge_fault;
	logic              temperature_marginal;

	modport source (
		output valid, battery_voltage, charge_current, charger_present,
		output overvoltage_cleared, overvoltage_fault, temperature_fault,
		output thermistor_fault, charge_fault, temperature_marginal,
		input  ready
	);
	modport sink (
		input  valid, battery_voltage, charge_current, charger_present,
		input  overvoltage_cleared, overvoltage_fault, temperature_fault,
		input  thermistor_fault, charge_fault, temperature_marginal,
		output ready
	);
endinterface

// Result channel: one request per tick.
interface lic_result_if;
	import lic_pkg::*;

	logic               valid;
	logic               ready;
	logic               charge_enable;
	logic [DUTY_W-1:0]  pwm_duty;
	logic [PHASE_W-1:0] charge_phase;
	logic               charge_complete;
	logic [VOLT_W-1:0]  cv_target_voltage;
	logic [STEPS_W-1:0] step_down_count;

	modport source (
		output valid, charge_enable, pwm_duty, charge_phase, charge_complete,
		output cv_target_voltage, step_down_count,
		input  ready
	);
	modport sink (
		input  valid, charge_enable, pwm_duty, charge_phase, charge_complete,
		input  cv_target_voltage, step_down_count,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/lic_cfg.sv =====
`default_nettype none

module lic_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         we,
	input  wire logic [lic_pkg::CFG_IDX_W-1:0] index,
	input  wire logic [lic_pkg::CFG_W-1:0]     data,
	output lic_pkg::lic_cfg_t                 cfg
);
	import lic_pkg::*;

	lic_cfg_t cfg_q;

	// threshold registers, written one at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_start   <= RST_FULL_START;
			cfg_q.pre_limit    <= RST_PRE_LIMIT;
			cfg_q.cc_entry     <= RST_CC_ENTRY;
			cfg_q.cv_entry     <= RST_CV_ENTRY;
			cfg_q.recharge     <= RST_RECHARGE;
			cfg_q.pre_current  <= RST_PRE_CURRENT;
			cfg_q.cc_current   <= RST_CC_CURRENT;
			cfg_q.term_current <= RST_TERM_CURRENT;
		end else if (we) begin
			case (cfg_idx_t'(index))
				REG_FULL_START:   cfg_q.full_start   <= data;
				REG_PRE_LIMIT:    cfg_q.pre_limit    <= data;
				REG_CC_ENTRY:     cfg_q.cc_entry     <= data;
				REG_CV_ENTRY:     cfg_q.cv_entry     <= data;
				REG_RECHARGE:     cfg_q.recharge     <= data;
				REG_PRE_CURRENT:  cfg_q.pre_current  <= data;
				REG_CC_CURRENT:   cfg_q.cc_current   <= data;
				REG_TERM_CURRENT: cfg_q.term_current <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/lic_step.sv =====
`default_nettype none

// Next state per tick: phase walk, duty steps, CV and recharge timers.
module lic_step (
	input  wire lic_pkg::lic_cfg_t   cfg,
	input  wire lic_pkg::lic_tick_t  tick,
	input  wire lic_pkg::lic_state_t st,
	output lic_pkg::lic_state_t      nxt,
	output logic                     enable
);
	import lic_pkg::*;

	// one duty step: down wins over up, clamped to 0..DUTY_MAX
	function automatic logic [DUTY_W-1:0] duty_step(input logic [DUTY_W-1:0] d,
			input logic dn, input logic up);
		logic [DUTY_W-1:0] r;
		r = d;
		if (dn) begin
			if (d != '0) r = d - 10'd1;
		end else if (up) begin
			if (d < DUTY_MAX) r = d + 10'd1;
		end
		return r;
	endfunction

	logic                 gate;
	logic [CUR_W:0]       cur_x;
	logic [VOLT_W:0]      volt_x;
	logic                 pre_dn, pre_up, cc_dn, cc_up, cv_dn, cv_up;
	logic [2:0]           drop_n;
	logic [VOLT_W-1:0]    cv_entry_tgt;
	logic [TIMER_W-1:0]   timer_inc;
	logic [FULL_W-1:0]    full_inc;
	logic [RECH_W-1:0]    rech_inc;
	logic [VOLT_W-1:0]    cv_dec;

	assign gate = tick.present && tick.ov_cleared && !tick.ov_fault && !tick.temp_fault
		&& !tick.therm_fault && !tick.chg_fault;

	// hysteresis band compares, one bit wider so band edges never wrap
	assign cur_x  = {1'b0, tick.current};
	assign volt_x = {1'b0, tick.voltage};
	assign pre_dn = cur_x > ({1'b0, cfg.pre_current} + {1'b0, CUR_BAND});
	assign pre_up = (cur_x + {1'b0, CUR_BAND}) < {1'b0, cfg.pre_current};
	assign cc_dn  = tick.current > cfg.cc_current;
	assign cc_up  = (cur_x + {1'b0, CUR_BAND}) < {1'b0, cfg.cc_current};
	assign cv_dn  = tick.voltage > st.cv_target;
	assign cv_up  = (volt_x + {1'b0, CV_BAND}) < {1'b0, st.cv_target};

	// CV entry target: one count lower per step current not below the sample
	assign drop_n = 3'(tick.current <= STEP_CURRENT_A) + 3'(tick.current <= STEP_CURRENT_B)
		+ 3'(tick.current <= STEP_CURRENT_C) + 3'(tick.current <= STEP_CURRENT_D);
	assign cv_entry_tgt = (cfg.cv_entry > {9'd0, drop_n}) ? cfg.cv_entry - {9'd0, drop_n}
		: '0;

	assign timer_inc = st.cv_timer + 13'd1;
	assign full_inc  = st.full_cnt + 10'd1;
	assign rech_inc  = st.rech_cnt + 5'd1;
	assign cv_dec    = (st.cv_target != '0) ? st.cv_target - 12'd1 : '0;

	always_comb begin
		nxt    = st;
		enable = 1'b0;
		if (gate) begin
			if (st.phase == PH_IDLE && tick.voltage >= cfg.full_start) nxt.complete = 1'b1;
			if (!nxt.complete) begin
				if (!tick.temp_marginal) begin
					// phase entries that regulate in the same tick
					if (st.phase == PH_IDLE) begin
						if (tick.voltage != '0 && tick.voltage < cfg.pre_limit) begin
							nxt.phase = PH_PRE;
							nxt.duty  = DUTY_PRE;
						end else if (tick.voltage >= cfg.pre_limit
								&& tick.voltage < cfg.full_start) begin
							nxt.phase = PH_CC;
							nxt.duty  = DUTY_CC;
						end
					end else if (st.phase == PH_RED) begin
						nxt.phase = PH_PRE;
						nxt.duty  = DUTY_PRE;
					end
					case (nxt.phase)
						PH_PRE: begin
							nxt.duty = duty_step(nxt.duty, pre_dn, pre_up);
							if (tick.voltage >= cfg.cc_entry) begin
								nxt.phase = PH_CC;
								nxt.duty  = DUTY_CC;
							end
						end
						PH_CC: begin
							nxt.duty = duty_step(nxt.duty, cc_dn, cc_up);
							if (tick.voltage >= cfg.cv_entry) begin
								nxt.phase      = PH_CV;
								nxt.cv_target  = cv_entry_tgt;
								nxt.cv_timer   = '0;
								nxt.full_cnt   = '0;
								nxt.step_downs = '0;
							end
						end
						PH_CV: begin
							nxt.duty = duty_step(nxt.duty, cv_dn, cv_up);
							// timed target step-down
							if (timer_inc >= CV_STEP_TICKS) begin
								nxt.cv_timer  = '0;
								nxt.cv_target = cv_dec;
								if (st.step_downs != '1) nxt.step_downs = st.step_downs + 8'd1;
							end else begin
								nxt.cv_timer = timer_inc;
							end
							// termination debounce, leaky on high current
							if (tick.current < cfg.term_current) begin
								if (full_inc >= FULL_TICKS) begin
									nxt.full_cnt = '0;
									nxt.complete = 1'b1;
								end else begin
									nxt.full_cnt = full_inc;
								end
							end else begin
								nxt.full_cnt = (st.full_cnt >= FULL_DROP)
									? st.full_cnt - FULL_DROP : '0;
							end
						end
						default: ;
					endcase
				end else begin
					nxt.phase = PH_RED;
					nxt.duty  = duty_step(st.duty, pre_dn, pre_up);
				end
				enable = 1'b1;
			end else begin
				// finished: restart after a debounced low voltage
				if (tick.voltage <= cfg.recharge) begin
					if (rech_inc >= RECHARGE_TICKS) begin
						nxt.rech_cnt = '0;
						nxt.complete = 1'b0;
						nxt.phase    = PH_IDLE;
					end else begin
						nxt.rech_cnt = rech_inc;
					end
				end else begin
					nxt.rech_cnt = '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/li_ion_charge_controller.sv =====
// Channel  | Dir | Handshake    | Carries
// item     | in  | valid/ready  | voltage, current and flag samples of one tick
// result   | out | valid/ready  | enable, duty, phase, done, CV target, step-downs
// cfg      | in  | cfg_we       | threshold register index and 12-bit value
//
// One tick per cycle sustained unless the result stalls.
// The tick sits in an input register, one pass of next-state logic updates the
// charge state, and that state register doubles as the result register.
// A stalled result holds the state; the input register keeps taking ticks when
// the result moves on in the same cycle.
// Reset clears the charge state and loads threshold defaults; no clearing pass.
`default_nettype none

module li_ion_charge_controller (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lic_item_if.sink                           item,
	lic_result_if.source                       result,
	input  wire logic                          cfg_we,
	input  wire logic [lic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lic_pkg::CFG_W-1:0]     cfg_data
);
	import lic_pkg::*;

	`include "li_ion_charge_controller_assert.svh"

	lic_cfg_t   cfg;
	lic_tick_t  tick_s1;
	logic       valid_s1;
	lic_state_t state_q;
	lic_state_t state_nxt;
	logic       en_nxt;
	logic       en_q;
	logic       res_valid_q;
	logic       adv;

	lic_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	lic_step u_step (
		.cfg    (cfg),
		.tick   (tick_s1),
		.st     (state_q),
		.nxt    (state_nxt),
		.enable (en_nxt)
	);

	// tick moves into the state when the result slot is free or being taken
	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			tick_s1.voltage       <= item.battery_voltage;
			tick_s1.current       <= item.charge_current;
			tick_s1.present       <= item.charger_present;
			tick_s1.ov_cleared    <= item.overvoltage_cleared;
			tick_s1.ov_fault      <= item.overvoltage_fault;
			tick_s1.temp_fault    <= item.temperature_fault;
			tick_s1.therm_fault   <= item.thermistor_fault;
			tick_s1.chg_fault     <= item.charge_fault;
			tick_s1.temp_marginal <= item.temperature_marginal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// charge state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			en_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q     <= state_nxt;
				en_q        <= en_nxt;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid             = res_valid_q;
	assign result.charge_enable     = en_q;
	assign result.pwm_duty          = state_q.duty;
	assign result.charge_phase      = state_q.phase;
	assign result.charge_complete   = state_q.complete;
	assign result.cv_target_voltage = state_q.cv_target;
	assign result.step_down_count   = state_q.step_downs;

	`LIC_ASSERT_NEXT(a_state_hold, !adv, $stable(state_q) && $stable(en_q),
		"charge state changed without a tick")
	`LIC_ASSERT_NEXT(a_result_load, adv, res_valid_q,
		"tick consumed without a result request")
	`LIC_ASSERT_NOW(a_duty_range, res_valid_q, state_q.duty <= DUTY_MAX,
		"pwm duty above clamp")
	`LIC_ASSERT_NOW(a_rech_only_done, state_q.rech_cnt != '0, state_q.complete,
		"recharge debounce running while charge not finished")
	`LIC_ASSERT_NOW(a_cv_timer_range, 1'b1, state_q.cv_timer < CV_STEP_TICKS,
		"CV step timer past its period")

endmodule

`default_nettype wire
